### hdl/cda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

	localparam int REQ_W  = 64;
	localparam int RES_W  = 72;
	localparam int YEAR_W = 15;
	localparam int ACC_W  = 23;

	typedef enum logic [1:0] {
		MODE_CHECK = 2'd0,
		MODE_ADD   = 2'd1,
		MODE_DIFF  = 2'd2,
		MODE_CMP   = 2'd3
	} mode_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SETUP = 6'b000010,
		ST_ADDYR = 6'b000100,
		ST_ADDMO = 6'b001000,
		ST_DIFF  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	// fields from the lowest bit up: year_a, month_a, day_a, year_b, month_b, day_b, day_offset
	typedef struct packed {
		logic [1:0]  pad;
		logic [15:0] day_offset;
		logic [4:0]  day_b;
		logic [3:0]  month_b;
		logic [13:0] year_b;
		logic [4:0]  day_a;
		logic [3:0]  month_a;
		logic [13:0] year_a;
	} req_t;

	// fields from the lowest bit up: date_ok, out_year, out_month, out_day, year_overflow,
	// day_count, compare_value
	typedef struct packed {
		logic               pad;
		logic signed [23:0] compare_value;
		logic [21:0]        day_count;
		logic               year_overflow;
		logic [4:0]         out_day;
		logic [3:0]         out_month;
		logic [13:0]        out_year;
		logic               date_ok;
	} res_t;

	localparam logic [3:0]       MON_JAN       = 4'd1;
	localparam logic [3:0]       MON_FEB       = 4'd2;
	localparam logic [3:0]       MON_APR       = 4'd4;
	localparam logic [3:0]       MON_JUN       = 4'd6;
	localparam logic [3:0]       MON_SEP       = 4'd9;
	localparam logic [3:0]       MON_NOV       = 4'd11;
	localparam logic [3:0]       MON_DEC       = 4'd12;
	localparam logic [13:0]      YMOD_BASE     = 14'd400;
	localparam logic [2:0]       YMOD_STEPS    = 3'd5;
	localparam logic [8:0]       R400_LAST     = 9'd399;
	localparam logic [8:0]       R400_C1       = 9'd100;
	localparam logic [8:0]       R400_C2       = 9'd200;
	localparam logic [8:0]       R400_C3       = 9'd300;
	localparam logic [YEAR_W-1:0] YEARS_400    = 15'd400;
	localparam logic [ACC_W-1:0] DAYS_400Y     = 23'd146097;
	localparam logic [ACC_W-1:0] DAYS_YEAR     = 23'd365;
	localparam logic [21:0]      DAY_COUNT_MAX = 22'h3FFFFF;

	function automatic logic is_leap(input logic [8:0] r400, input logic [1:0] ylo);
		return (r400 == '0) ||
			((ylo == 2'd0) && (r400 != R400_C1) && (r400 != R400_C2) && (r400 != R400_C3));
	endfunction

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
		logic [4:0] len;
		case (m)
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
			MON_FEB: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

### hdl/calendar_date_arithmetic_top.sv
// check and compare: a year mod 400 reduction in ST_SETUP, then the result in ST_FIN
// add: after the reduction, ST_ADDYR walks whole years and ST_ADDMO walks months, then ST_FIN
// difference: after the reduction, ST_DIFF walks 400-year blocks, whole years and months
// input: a beat is taken only while idle, once the last one has finished; the result register
// lets the next beat in while a result waits
// reset: arst_n clears the sequencer and the output valid, the block comes up idle
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_arithmetic_top #(
	parameter int MAX_YEAR    = 9999,
	parameter int OFFSET_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// year_a, month_a, day_a, year_b, month_b, day_b, day_offset
	input  wire logic [cda_pkg::REQ_W-1:0]   s_tdata,
	// mode
	input  wire logic [1:0]                  s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// date_ok, out_year, out_month, out_day, year_overflow, day_count, compare_value
	output logic [cda_pkg::RES_W-1:0]        m_tdata
);
	import cda_pkg::*;

	localparam int OFS_W = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;

	state_t              state_q;
	mode_t               mode_q;
	req_t                in_q;
	req_t                req;
	res_t                res_q;
	res_t                res_c;
	logic                out_valid_q;
	logic [YEAR_W-1:0]   y_q;
	logic [3:0]          m_q;
	logic [8:0]          r400_q;
	logic [13:0]         rem_q;
	logic [2:0]          k_q;
	logic [ACC_W-1:0]    acc_q;
	logic [4:0]          d_q;

	logic                leap;
	logic [4:0]          mlen;
	logic [ACC_W-1:0]    ylen;
	logic [8:0]          r400_inc;
	logic [13:0]         ymod_step;
	logic [13:0]         rem_nx;
	logic [YEAR_W-1:0]   yb;
	logic [YEAR_W-1:0]   y_p400;
	logic                ygt;
	logic                ylt;
	logic                inner;
	logic                big;
	logic                alu_sub;
	logic [ACC_W-1:0]    alu_b;
	logic [ACC_W:0]      alu_res;
	logic                alu_gt;
	logic                fin_load;
	logic                zero_case;
	logic signed [ACC_W+1:0] dv;
	logic signed [23:0]  dy;
	logic signed [23:0]  dm;
	logic signed [23:0]  dd;

	assign req      = req_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

	assign leap      = is_leap(r400_q, y_q[1:0]);
	assign mlen      = month_len(leap, m_q);
	assign ylen      = DAYS_YEAR + ACC_W'(leap);
	assign r400_inc  = (r400_q == R400_LAST) ? '0 : r400_q + 9'd1;
	assign ymod_step = YMOD_BASE << k_q;
	assign rem_nx    = (rem_q >= ymod_step) ? rem_q - ymod_step : rem_q;

	assign yb     = {1'b0, in_q.year_b};
	assign y_p400 = y_q + YEARS_400;
	assign ygt    = y_q > yb;
	assign ylt    = y_q < yb;
	assign inner  = (ylt || (m_q < in_q.month_b)) && (m_q <= MON_DEC);
	assign big    = (m_q == MON_JAN) && (y_p400 <= yb);

	// shared day accumulator unit
	always_comb begin
		alu_sub = 1'b1;
		alu_b   = '0;
		case (state_q)
			ST_ADDYR: alu_b = ylen;
			ST_ADDMO: alu_b = ACC_W'(mlen);
			ST_DIFF: begin
				alu_sub = 1'b0;
				if (big) begin
					alu_b = DAYS_400Y;
				end else if ((m_q == MON_JAN) && ylt) begin
					alu_b = ylen;
				end else begin
					alu_b = ACC_W'(mlen);
				end
			end
			default: alu_b = '0;
		endcase
	end

	assign alu_res = alu_sub ? {1'b0, acc_q} - {1'b0, alu_b} : {1'b0, acc_q} + {1'b0, alu_b};
	assign alu_gt  = !alu_res[ACC_W] && (alu_res[ACC_W-1:0] != '0);

	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	assign zero_case = (acc_q == '0) && ((in_q.year_a > in_q.year_b) ||
		(in_q.month_a > in_q.month_b) || (in_q.day_a > in_q.day_b));
	assign dv = $signed({2'b00, acc_q}) + $signed({{(ACC_W-3){1'b0}}, in_q.day_b})
		- $signed({{(ACC_W-3){1'b0}}, in_q.day_a});
	assign dy = 24'($signed({1'b0, in_q.year_a}) - $signed({1'b0, in_q.year_b}));
	assign dm = 24'($signed({1'b0, in_q.month_a}) - $signed({1'b0, in_q.month_b}));
	assign dd = 24'($signed({1'b0, in_q.day_a}) - $signed({1'b0, in_q.day_b}));

	always_comb begin
		res_c = '0;
		case (mode_q)
			MODE_CHECK: begin
				res_c.date_ok = (in_q.year_a != '0) && (m_q >= MON_JAN) && (m_q <= MON_DEC) &&
					(in_q.day_a != '0) && (in_q.day_a <= mlen);
			end
			MODE_ADD: begin
				res_c.out_year      = y_q[13:0];
				res_c.out_month     = m_q;
				res_c.out_day       = d_q;
				res_c.year_overflow = y_q > YEAR_W'(MAX_YEAR);
			end
			MODE_DIFF: begin
				if (zero_case || (dv < 0)) begin
					res_c.day_count = '0;
				end else if (dv > $signed({3'b000, DAY_COUNT_MAX})) begin
					res_c.day_count = DAY_COUNT_MAX;
				end else begin
					res_c.day_count = dv[21:0];
				end
			end
			MODE_CMP: begin
				res_c.compare_value = (dy <<< 9) + (dm <<< 5) + dd;
			end
			default: res_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (k_q == '0) begin
						case (mode_q)
							MODE_ADD: begin
								if (acc_q == '0) begin
									state_q <= ST_FIN;
								end else if (m_q == MON_JAN) begin
									state_q <= ST_ADDYR;
								end else begin
									state_q <= ST_ADDMO;
								end
							end
							MODE_DIFF: state_q <= ST_DIFF;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_ADDYR: begin
					if (!alu_gt) begin
						state_q <= ST_ADDMO;
					end
				end
				ST_ADDMO: begin
					if (!alu_gt) begin
						state_q <= ST_FIN;
					end else if (m_q >= MON_DEC) begin
						state_q <= ST_ADDYR;
					end
				end
				ST_DIFF: begin
					if (ygt) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			res_q <= res_c;
		end
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					in_q   <= req;
					mode_q <= mode_t'(s_tuser);
					rem_q  <= req.year_a;
					k_q    <= YMOD_STEPS;
					y_q    <= {1'b0, req.year_a};
					m_q    <= req.month_a;
					d_q    <= '0;
					if (mode_t'(s_tuser) == MODE_ADD) begin
						acc_q <= ACC_W'(req.day_offset[OFS_W-1:0]) + ACC_W'(req.day_a);
					end else begin
						acc_q <= '0;
					end
				end
			end
			ST_SETUP: begin
				rem_q <= rem_nx;
				k_q   <= k_q - 3'd1;
				if (k_q == '0) begin
					r400_q <= rem_nx[8:0];
				end
			end
			ST_ADDYR: begin
				if (alu_gt) begin
					acc_q  <= alu_res[ACC_W-1:0];
					y_q    <= y_q + YEAR_W'(1);
					r400_q <= r400_inc;
				end
			end
			ST_ADDMO: begin
				if (alu_gt) begin
					acc_q <= alu_res[ACC_W-1:0];
					if (m_q >= MON_DEC) begin
						y_q    <= y_q + YEAR_W'(1);
						r400_q <= r400_inc;
						m_q    <= MON_JAN;
					end else begin
						m_q <= m_q + 4'd1;
					end
				end else begin
					d_q   <= acc_q[4:0];
					acc_q <= '0;
					if (m_q > MON_DEC) begin
						y_q    <= y_q + YEAR_W'(1);
						r400_q <= r400_inc;
						m_q    <= MON_JAN;
					end
				end
			end
			ST_DIFF: begin
				if (!ygt) begin
					if (inner) begin
						acc_q <= alu_res[ACC_W-1:0];
						if (big) begin
							y_q <= y_p400;
						end else if ((m_q == MON_JAN) && ylt) begin
							y_q    <= y_q + YEAR_W'(1);
							r400_q <= r400_inc;
						end else begin
							m_q <= m_q + 4'd1;
						end
					end else begin
						m_q    <= MON_JAN;
						y_q    <= y_q + YEAR_W'(1);
						r400_q <= r400_inc;
					end
				end
			end
			default: begin
			end
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a beat");

	a_add_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDYR || state_q == ST_ADDMO) |-> acc_q != '0)
		else $error("add walk running with no days left");

	a_year_step_jan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADDYR |-> m_q == MON_JAN)
		else $error("whole year step off january");

	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> m_tvalid && s_tready)
		else $error("finished result not presented");

endmodule

`default_nettype wire
